>>> hw/rtl/clwr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clwr_pkg
// Shared types and constants for the cache lookup with replacement block.
// ----------------------------------------------------------------------------
package clwr_pkg;

    localparam int RANK_W  = 32;
    localparam int TOTAL_W = 32;

    localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // mapping_mode codes
    localparam logic [1:0] MAP_DIRECT = 2'd0;
    localparam logic [1:0] MAP_SET2   = 2'd1;
    localparam logic [1:0] MAP_FULL   = 2'd2;

    // replacement_policy codes
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_LFU  = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAPPING = 1'b0;
    localparam logic CFG_POLICY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/clwr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clwr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module clwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/cache_lookup_with_replacement.sv
`default_nettype none
// Walk: N = slots walked, one slot per cycle through the single read port of the
//   tag and rank memories (1 direct, 2 set, ENTRIES fully associative; the walk
//   stops at the slot that hits). A new item is accepted only when idle, after the
//   previous result is registered; a waiting result holds the update.
// Reset: valid bits, totals, stamp and configuration clear at once; no clearing
//   pass, tag and rank memory contents are only used for valid slots.
// ----------------------------------------------------------------------------
// cache_lookup_with_replacement
// Cache directory with direct, two-way or fully associative mapping and
// FIFO / LRU / LFU victim choice, with saturating hit and miss statistics.
// ----------------------------------------------------------------------------
module cache_lookup_with_replacement
    import clwr_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,

    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire  [1:0]   cfg_wdata,

    input  wire          s_valid,
    output logic         s_ready,
    input  wire  [15:0]  s_req_address,

    output logic         m_valid,
    input  wire          m_ready,
    output logic         m_hit,
    output logic [3:0]   m_slot,
    output logic         m_evicted_valid,
    output logic [15:0]  m_evicted_address,
    output logic [4:0]   m_lookup_probes,
    output logic [4:0]   m_fill_probes,
    output logic [31:0]  m_hits_total,
    output logic [31:0]  m_misses_total,
    output logic [31:0]  m_hit_time_total,
    output logic [31:0]  m_miss_penalty_total
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LG     = $clog2(ENTRIES + 1) - 1;   // floor(log2(ENTRIES))
    localparam int TAG_W  = (ADDR_BITS < 16) ? ADDR_BITS : 16;
    localparam logic [15:0] ADDR_MASK = 16'((17'd1 << TAG_W) - 17'd1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

    // configuration
    logic [1:0] mode_reg, policy_reg;
    logic [1:0] policy_eff;

    // control
    state_t                 state_reg, state_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [TAG_W-1:0]       addr_reg, addr_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [SLOT_W-1:0]      last_reg, last_next;
    logic                   first_step_reg, first_step_next;
    logic [CNT_W-1:0]       lprobe_reg, lprobe_next;
    logic [CNT_W-1:0]       fprobe_reg, fprobe_next;
    logic                   hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0]      hit_slot_reg, hit_slot_next;
    logic [RANK_W-1:0]      hit_rank_reg, hit_rank_next;
    logic                   empty_found_reg, empty_found_next;
    logic [SLOT_W-1:0]      empty_slot_reg, empty_slot_next;
    logic [SLOT_W-1:0]      best_slot_reg, best_slot_next;
    logic [RANK_W-1:0]      best_rank_reg, best_rank_next;
    logic [TAG_W-1:0]       best_tag_reg, best_tag_next;
    logic [RANK_W-1:0]      stamp_reg, stamp_next;
    logic [TOTAL_W-1:0]     hits_reg, hits_next;
    logic [TOTAL_W-1:0]     misses_reg, misses_next;
    logic [TOTAL_W-1:0]     probes_reg, probes_next;
    logic [TOTAL_W-1:0]     penalty_reg, penalty_next;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic                   m_hit_reg, m_hit_next;
    logic [3:0]             m_slot_reg, m_slot_next;
    logic                   m_ev_valid_reg, m_ev_valid_next;
    logic [15:0]            m_ev_addr_reg, m_ev_addr_next;
    logic [4:0]             m_lprobe_reg, m_lprobe_next;
    logic [4:0]             m_fprobe_reg, m_fprobe_next;

    // memory ports
    logic [SLOT_W-1:0]      rd_addr;
    logic [TAG_W-1:0]       tag_rd;
    logic [RANK_W-1:0]      rank_rd;
    logic                   tag_we, rank_we;
    logic [SLOT_W-1:0]      wr_addr;
    logic [RANK_W-1:0]      rank_wdata;

    // range of the incoming item
    logic [15:0]            addr_m;
    logic [SLOT_W-1:0]      first_calc, last_calc;

    logic                   slot_valid, hit_now, out_free;
    logic [SLOT_W-1:0]      fill_slot;
    logic [RANK_W-1:0]      stamp_inc;
    logic [RANK_W-1:0]      fill_rank;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    assign policy_eff = (policy_reg == POL_LRU || policy_reg == POL_LFU) ? policy_reg
                                                                         : POL_FIFO;

    assign addr_m = s_req_address & ADDR_MASK;

    always_comb begin
        case (mode_reg)
            MAP_DIRECT: begin
                first_calc = SLOT_W'(addr_m[LG-1:0]);
                last_calc  = first_calc;
            end
            MAP_SET2: begin
                first_calc = SLOT_W'({addr_m[LG-2:0], 1'b0});
                last_calc  = first_calc | SLOT_W'(1);
            end
            default: begin
                first_calc = '0;
                last_calc  = LAST_SLOT;
            end
        endcase
    end

    assign slot_valid = valid_reg[idx_reg];
    assign hit_now    = slot_valid && (tag_rd == addr_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign fill_slot  = empty_found_reg ? empty_slot_reg : best_slot_reg;
    assign stamp_inc  = stamp_reg + RANK_W'(1);
    assign fill_rank  = (policy_eff == POL_FIFO) ? stamp_inc : stamp_inc + RANK_W'(1);

    always_comb begin
        rd_addr = idx_reg;
        case (state_reg)
            ST_IDLE: rd_addr = first_calc;
            ST_WALK: rd_addr = (idx_reg == last_reg) ? idx_reg : idx_reg + SLOT_W'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        last_next        = last_reg;
        first_step_next  = first_step_reg;
        lprobe_next      = lprobe_reg;
        fprobe_next      = fprobe_reg;
        hit_found_next   = hit_found_reg;
        hit_slot_next    = hit_slot_reg;
        hit_rank_next    = hit_rank_reg;
        empty_found_next = empty_found_reg;
        empty_slot_next  = empty_slot_reg;
        best_slot_next   = best_slot_reg;
        best_rank_next   = best_rank_reg;
        best_tag_next    = best_tag_reg;
        stamp_next       = stamp_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        probes_next      = probes_reg;
        penalty_next     = penalty_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_hit_next       = m_hit_reg;
        m_slot_next      = m_slot_reg;
        m_ev_valid_next  = m_ev_valid_reg;
        m_ev_addr_next   = m_ev_addr_reg;
        m_lprobe_next    = m_lprobe_reg;
        m_fprobe_next    = m_fprobe_reg;
        tag_we           = 1'b0;
        rank_we          = 1'b0;
        wr_addr          = fill_slot;
        rank_wdata       = fill_rank;
        s_ready          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    addr_next        = addr_m[TAG_W-1:0];
                    idx_next         = first_calc;
                    last_next        = last_calc;
                    first_step_next  = 1'b1;
                    lprobe_next      = '0;
                    fprobe_next      = '0;
                    hit_found_next   = 1'b0;
                    empty_found_next = 1'b0;
                    state_next       = ST_WALK;
                end
            end

            ST_WALK: begin
                first_step_next = 1'b0;
                lprobe_next     = lprobe_reg + CNT_W'(1);
                if (hit_now) begin
                    hit_found_next = 1'b1;
                    hit_slot_next  = idx_reg;
                    hit_rank_next  = rank_rd;
                    state_next     = ST_UPDATE;
                end else begin
                    if (!empty_found_reg) begin
                        fprobe_next = fprobe_reg + CNT_W'(1);
                        if (!slot_valid) begin
                            empty_found_next = 1'b1;
                            empty_slot_next  = idx_reg;
                        end
                    end
                    // keep the first lowest rank on a tie
                    if (first_step_reg || rank_rd < best_rank_reg) begin
                        best_slot_next = idx_reg;
                        best_rank_next = rank_rd;
                        best_tag_next  = tag_rd;
                    end
                    if (idx_reg == last_reg) begin
                        state_next = ST_UPDATE;
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            ST_UPDATE: begin
                if (out_free) begin
                    probes_next     = sat_add(probes_reg, TOTAL_W'(lprobe_reg));
                    m_valid_next    = 1'b1;
                    m_hit_next      = hit_found_reg;
                    m_lprobe_next   = 5'(lprobe_reg);
                    state_next      = ST_IDLE;
                    if (hit_found_reg) begin
                        hits_next       = sat_add(hits_reg, TOTAL_W'(1));
                        m_slot_next     = 4'(hit_slot_reg);
                        m_ev_valid_next = 1'b0;
                        m_ev_addr_next  = '0;
                        m_fprobe_next   = '0;
                        wr_addr         = hit_slot_reg;
                        if (policy_eff == POL_LRU) begin
                            rank_we    = 1'b1;
                            rank_wdata = fill_rank;
                            stamp_next = stamp_inc;
                        end else if (policy_eff == POL_LFU) begin
                            rank_we    = 1'b1;
                            rank_wdata = (hit_rank_reg == RANK_MAX) ? RANK_MAX
                                                                    : hit_rank_reg + RANK_W'(1);
                        end
                    end else begin
                        misses_next          = sat_add(misses_reg, TOTAL_W'(1));
                        penalty_next         = sat_add(penalty_reg, TOTAL_W'(fprobe_reg));
                        m_slot_next          = 4'(fill_slot);
                        m_ev_valid_next      = !empty_found_reg;
                        m_ev_addr_next       = empty_found_reg ? 16'd0 : 16'(best_tag_reg);
                        m_fprobe_next        = 5'(fprobe_reg);
                        tag_we               = 1'b1;
                        rank_we              = 1'b1;
                        rank_wdata           = fill_rank;
                        stamp_next           = stamp_inc;
                        valid_next[fill_slot] = 1'b1;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            mode_reg    <= MAP_DIRECT;
            policy_reg  <= POL_FIFO;
            stamp_reg   <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            probes_reg  <= '0;
            penalty_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            stamp_reg   <= stamp_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            probes_reg  <= probes_next;
            penalty_reg <= penalty_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAPPING: mode_reg   <= cfg_wdata;
                    CFG_POLICY:  policy_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg        <= addr_next;
        idx_reg         <= idx_next;
        last_reg        <= last_next;
        first_step_reg  <= first_step_next;
        lprobe_reg      <= lprobe_next;
        fprobe_reg      <= fprobe_next;
        hit_found_reg   <= hit_found_next;
        hit_slot_reg    <= hit_slot_next;
        hit_rank_reg    <= hit_rank_next;
        empty_found_reg <= empty_found_next;
        empty_slot_reg  <= empty_slot_next;
        best_slot_reg   <= best_slot_next;
        best_rank_reg   <= best_rank_next;
        best_tag_reg    <= best_tag_next;
        m_hit_reg       <= m_hit_next;
        m_slot_reg      <= m_slot_next;
        m_ev_valid_reg  <= m_ev_valid_next;
        m_ev_addr_reg   <= m_ev_addr_next;
        m_lprobe_reg    <= m_lprobe_next;
        m_fprobe_reg    <= m_fprobe_next;
    end

    clwr_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_we),
        .wr_addr (wr_addr),
        .wr_data (addr_reg),
        .rd_addr (rd_addr),
        .rd_data (tag_rd)
    );

    clwr_ram #(
        .WIDTH (RANK_W),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (wr_addr),
        .wr_data (rank_wdata),
        .rd_addr (rd_addr),
        .rd_data (rank_rd)
    );

    assign m_valid              = m_valid_reg;
    assign m_hit                = m_hit_reg;
    assign m_slot               = m_slot_reg;
    assign m_evicted_valid      = m_ev_valid_reg;
    assign m_evicted_address    = m_ev_addr_reg;
    assign m_lookup_probes      = m_lprobe_reg;
    assign m_fill_probes        = m_fprobe_reg;
    assign m_hits_total         = hits_reg;
    assign m_misses_total       = misses_reg;
    assign m_hit_time_total     = probes_reg;
    assign m_miss_penalty_total = penalty_reg;

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (idx_reg <= last_reg))
        else $error("walk index past end of range");

    a_hit_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hit_reg) |-> (!m_ev_valid_reg && m_fprobe_reg == 5'd0))
        else $error("hit result reports fill activity");

    a_one_total_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && out_free) |=>
            (hits_reg == $past(hits_reg) || misses_reg == $past(misses_reg)))
        else $error("hit and miss totals both advanced");

    a_totals_hold_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> $stable(hits_reg) && $stable(misses_reg))
        else $error("totals changed outside update");

endmodule

`default_nettype wire

>>> dv/cache_lookup_with_replacement_test.sv
// ----------------------------------------------------------------------------
// cache_lookup_with_replacement_test
// Drives address lookups through the cache directory under all mapping modes
// and replacement policies, predicts every hit, fill, eviction and running
// total, and compares each result field against the prediction.
// ----------------------------------------------------------------------------
import clwr_pkg::*;

localparam int         SLOTS        = 16;
// Out-of-range register codes; the block folds them onto valid ones.
localparam logic [1:0] MAP_ALT_FULL = 2'd3;
localparam logic [1:0] POL_ALT_FIFO = 2'd3;

typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evicted_valid;
    logic [15:0] evicted_address;
    logic [4:0]  lookup_probes;
    logic [4:0]  fill_probes;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
    logic [31:0] hit_time_total;
    logic [31:0] miss_penalty_total;
} lookup_outcome_t;

class cache_scoreboard;
    logic [1:0]      map_mode = MAP_DIRECT;
    logic [1:0]      policy   = POL_FIFO;
    bit              line_valid [SLOTS];
    logic [15:0]     line_tag   [SLOTS];
    logic [31:0]     line_rank  [SLOTS];
    logic [31:0]     stamp, hits, misses, probes, penalty;
    lookup_outcome_t expected_outcomes[$];
    int              errors, n_checked, n_hits, n_evictions;

    function new();
        foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = '0;
        end
        stamp   = '0;
        hits    = '0;
        misses  = '0;
        probes  = '0;
        penalty = '0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TOTAL_MAX : s[31:0];
    endfunction

    function logic [31:0] next_stamp(logic [1:0] pol);
        stamp = stamp + 1;
        return (pol == POL_LRU || pol == POL_LFU) ? stamp + 2 - 1 : stamp;
    endfunction

    function void set_reg(logic idx, logic [1:0] val);
        if (idx == CFG_MAPPING) map_mode = val;
        else policy = val;
    endfunction

    function int pending();
        return expected_outcomes.size();
    endfunction

    // Predict the outcome of one accepted lookup and update the directory.
    function void note_request(logic [15:0] addr);
        int              first, last, slot_i, best, lp, fp;
        bit              found;
        logic [1:0]      pol;
        lookup_outcome_t o;
        o     = '0;
        lp    = 0;
        fp    = 0;
        found = 1'b0;
        slot_i = 0;
        pol   = (policy == POL_LRU || policy == POL_LFU) ? policy : POL_FIFO;
        case (map_mode)
            MAP_DIRECT: begin
                first = int'(addr[3:0]);
                last  = first;
            end
            MAP_SET2: begin
                first = int'({addr[2:0], 1'b0});
                last  = first + 1;
            end
            default: begin
                first = 0;
                last  = SLOTS - 1;
            end
        endcase
        for (int i = first; i <= last; i++) begin
            lp++;
            if (line_valid[i] && line_tag[i] == addr) begin
                o.hit  = 1'b1;
                slot_i = i;
                if (pol == POL_LRU) line_rank[i] = next_stamp(pol);
                else if (pol == POL_LFU) line_rank[i] = sat_add(line_rank[i], 1);
                break;
            end
        end
        probes = sat_add(probes, lp);
        if (o.hit) begin
            hits = sat_add(hits, 1);
            n_hits++;
        end else begin
            misses = sat_add(misses, 1);
            for (int i = first; i <= last; i++) begin
                fp++;
                if (!line_valid[i]) begin
                    slot_i = i;
                    found  = 1'b1;
                    break;
                end
            end
            if (!found) begin
                best = first;
                for (int i = first + 1; i <= last; i++)
                    if (line_rank[i] < line_rank[best]) best = i;
                slot_i            = best;
                o.evicted_valid   = 1'b1;
                o.evicted_address = line_tag[best];
                n_evictions++;
            end
            penalty            = sat_add(penalty, fp);
            line_valid[slot_i] = 1'b1;
            line_tag[slot_i]   = addr;
            line_rank[slot_i]  = next_stamp(pol);
        end
        o.slot               = slot_i[3:0];
        o.lookup_probes      = lp[4:0];
        o.fill_probes        = fp[4:0];
        o.hits_total         = hits;
        o.misses_total       = misses;
        o.hit_time_total     = probes;
        o.miss_penalty_total = penalty;
        expected_outcomes.insert(expected_outcomes.size(), o);
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_outcome(lookup_outcome_t got);
        lookup_outcome_t e;
        if (expected_outcomes.size() == 0) begin
            $error("result with no lookup outstanding: slot %0d", got.slot);
            errors++;
            return;
        end
        e = expected_outcomes.pop_front();
        n_checked++;
        compare("hit", e.hit, got.hit);
        compare("slot", e.slot, got.slot);
        compare("evicted_valid", e.evicted_valid, got.evicted_valid);
        compare("evicted_address", e.evicted_address, got.evicted_address);
        compare("lookup_probes", e.lookup_probes, got.lookup_probes);
        compare("fill_probes", e.fill_probes, got.fill_probes);
        compare("hits_total", e.hits_total, got.hits_total);
        compare("misses_total", e.misses_total, got.misses_total);
        compare("hit_time_total", e.hit_time_total, got.hit_time_total);
        compare("miss_penalty_total", e.miss_penalty_total, got.miss_penalty_total);
    endfunction
endclass

module cache_lookup_with_replacement_test;

    localparam int STALL_LIMIT = 2000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = 1'b0;
    logic [1:0]  cfg_wdata     = 2'd0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [15:0] s_req_address = 16'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_hit;
    logic [3:0]  m_slot;
    logic        m_evicted_valid;
    logic [15:0] m_evicted_address;
    logic [4:0]  m_lookup_probes;
    logic [4:0]  m_fill_probes;
    logic [31:0] m_hits_total;
    logic [31:0] m_misses_total;
    logic [31:0] m_hit_time_total;
    logic [31:0] m_miss_penalty_total;

    cache_scoreboard sb = new();
    bit              no_idle = 1'b0;
    int              stall_cycles = 0;
    int              settings_run = 0;

    cache_lookup_with_replacement i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_address        (s_req_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_hit                (m_hit),
        .m_slot               (m_slot),
        .m_evicted_valid      (m_evicted_valid),
        .m_evicted_address    (m_evicted_address),
        .m_lookup_probes      (m_lookup_probes),
        .m_fill_probes        (m_fill_probes),
        .m_hits_total         (m_hits_total),
        .m_misses_total       (m_misses_total),
        .m_hit_time_total     (m_hit_time_total),
        .m_miss_penalty_total (m_miss_penalty_total)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Sample both handshakes with pre-edge values.
    always @(posedge aclk) begin
        lookup_outcome_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_req_address);
            if (m_valid && m_ready) begin
                got.hit                = m_hit;
                got.slot               = m_slot;
                got.evicted_valid      = m_evicted_valid;
                got.evicted_address    = m_evicted_address;
                got.lookup_probes      = m_lookup_probes;
                got.fill_probes        = m_fill_probes;
                got.hits_total         = m_hits_total;
                got.misses_total       = m_misses_total;
                got.hit_time_total     = m_hit_time_total;
                got.miss_penalty_total = m_miss_penalty_total;
                sb.check_outcome(got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Leave the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic idx, input logic [1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic send_item(input logic [15:0] addr);
        while (!no_idle && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_address <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every outstanding lookup has returned.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [1:0] map, input logic [1:0] pol);
        drain();
        write_reg(CFG_MAPPING, map);
        write_reg(CFG_POLICY, pol);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Mostly revisit a small pool so hits, fills and evictions all occur.
    task automatic run_random(input logic [1:0] map, input logic [1:0] pol, input int n);
        logic [15:0] pool[20];
        logic [15:0] addr;
        int          pick;
        apply_setting(map, pol);
        foreach (pool[k]) begin
            pool[k] = 16'($urandom_range(65535));
            // share low bits with an earlier entry to force conflicts
            if (k > 0 && $urandom_range(2) == 0) pool[k][3:0] = pool[k - 1][3:0];
        end
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(99);
            if (pick < 70) addr = pool[$urandom_range(19)];
            else if (pick < 75) addr = (pick[0]) ? 16'hFFFF : 16'h0000;
            else addr = 16'($urandom_range(65535));
            send_item(addr);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // direct mapped, FIFO: fill, hit, conflict eviction, field extremes
        apply_setting(MAP_DIRECT, POL_FIFO);
        send_item(16'h0000);
        send_item(16'h0000);
        send_item(16'hFFFF);
        send_item(16'h0010);
        send_item(16'hFFFF);
        send_item(16'h8000);
        send_item(16'h5555);
        send_item(16'hAAAA);

        // two-way, LRU: a hit restamps, so the other way goes first
        apply_setting(MAP_SET2, POL_LRU);
        send_item(16'h0003);
        send_item(16'h0013);
        send_item(16'h0003);
        send_item(16'h0023);
        send_item(16'h0003);

        // fully associative, LFU: contents kept across the register change
        apply_setting(MAP_FULL, POL_LFU);
        send_item(16'h1234);
        send_item(16'h1234);
        send_item(16'h1234);
        send_item(16'hFEDC);
        send_item(16'h0000);

        // reserved codes fold onto fully associative and FIFO
        apply_setting(MAP_ALT_FULL, POL_ALT_FIFO);
        send_item(16'h7FFF);
        send_item(16'h7FFF);
        send_item(16'h4321);

        run_random(MAP_SET2,     POL_FIFO,     53);
        run_random(MAP_FULL,     POL_LRU,      53);
        run_random(MAP_FULL,     POL_LFU,      53);
        no_idle = 1'b1;
        run_random(MAP_DIRECT,   POL_LRU,      53);
        drain();
        no_idle = 1'b0;
        run_random(MAP_SET2,     POL_LFU,      53);
        run_random(MAP_ALT_FULL, POL_ALT_FIFO, 53);
        run_random(MAP_DIRECT,   POL_LFU,      53);
        run_random(MAP_SET2,     POL_LRU,      53);
        run_random(MAP_FULL,     POL_FIFO,     53);

        drain();
        repeat (40) @(posedge aclk);

        $display("Checked %0d lookups (%0d hits, %0d evictions) across %0d register settings",
                 sb.n_checked, sb.n_hits, sb.n_evictions, settings_run);
        $display("All mapping modes and replacement policies ran, reserved codes included");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
